@@ src/adcsa_pkg.sv @@
// ----------------------------------------------------------------------------
// adcsa_pkg
// Shared types and constants of the ADC subscriber sample averager: request
// and response payloads, the slot table entry and the slot evaluation record.
// ----------------------------------------------------------------------------
`default_nettype none

package adcsa_pkg;

   // default number of subscriber slots
   localparam int SLOTS_DEFAULT = 8;

   // request kinds
   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // response kinds
   localparam logic RESULT_ACK     = 1'b0;
   localparam logic RESULT_READING = 1'b1;

   // request payload
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  channel;
      logic [11:0] sample_value;
      logic [7:0]  handler_id;
      logic [7:0]  average_count;
   } req_type;

   // response payload
   typedef struct packed {
      logic        result_kind;
      logic        success;
      logic [7:0]  reading_handler;
      logic [4:0]  reading_channel;
      logic [11:0] reading_value;
      logic        last;
   } rsp_type;

   // one entry of the slot table
   typedef struct packed {
      logic [7:0]  handler;
      logic [4:0]  channel;
      logic [7:0]  target;
      logic [7:0]  count;
      logic [11:0] value;
   } slot_type;

   // outcome of evaluating one slot against the current request
   typedef struct packed {
      logic     write;
      logic     set_active;
      logic     clr_active;
      logic     emit;
      logic     stop;
      slot_type wdata;
   } eval_type;

endpackage

`default_nettype wire

@@ src/adcsa_slot_mem.sv @@
// ----------------------------------------------------------------------------
// adcsa_slot_mem
// Slot table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module adcsa_slot_mem
   import adcsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire slot_type      wr_data,
   input  wire logic [IW-1:0] rd_addr,
   output slot_type           rd_data
);

   slot_type mem_ff [SLOTS];
   slot_type rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/adcsa_slot_unit.sv @@
// ----------------------------------------------------------------------------
// adcsa_slot_unit
// Shared slot evaluation unit: matches one slot entry against the current
// request and computes the updated entry, the running average and the flags.
// ----------------------------------------------------------------------------
`default_nettype none

module adcsa_slot_unit
   import adcsa_pkg::*;
(
   input  wire req_type  req,
   input  wire slot_type entry,
   input  wire logic     active,
   output eval_type      result
);

   logic        ch_match;
   logic        hd_match;
   logic [7:0]  cnt_next;
   logic [12:0] sum;
   logic [11:0] value_next;
   logic        hit;

   // match and arithmetic
   assign ch_match   = (entry.channel == req.channel);
   assign hd_match   = (entry.handler == req.handler_id);
   assign cnt_next   = entry.count + 8'd1;
   assign sum        = {1'b0, entry.value} + {1'b0, req.sample_value};
   assign value_next = (cnt_next == 8'd1) ? req.sample_value : sum[12:1];
   assign hit        = (cnt_next == entry.target);

   // per kind decision
   always_comb begin
      result = '0;
      result.wdata = entry;
      case (req.kind)
         KIND_SAMPLE: begin
            if (active && ch_match) begin
               result.write       = 1'b1;
               result.emit        = hit;
               result.wdata.count = hit ? 8'd0 : cnt_next;
               result.wdata.value = value_next;
            end
         end
         KIND_ADD: begin
            if (!active) begin
               result.write         = 1'b1;
               result.set_active    = 1'b1;
               result.stop          = 1'b1;
               result.wdata.handler = req.handler_id;
               result.wdata.channel = req.channel;
               result.wdata.target  = req.average_count;
               result.wdata.count   = 8'd0;
               result.wdata.value   = 12'd0;
            end
         end
         KIND_CANCEL: begin
            if (active && ch_match && hd_match) begin
               result.clr_active = 1'b1;
               result.stop       = 1'b1;
            end
         end
         default: begin
            result.write = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/adcsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// adcsa_ctrl
// Sequencer of the averager: walks the slot table one entry per cycle through
// the shared evaluation unit, keeps the active bits and the enable register,
// and queues one reading so the final result of a sample can carry last.
// ----------------------------------------------------------------------------
`default_nettype none

module adcsa_ctrl
   import adcsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  wire logic          csr_valid,
   input  wire logic          csr_wdata,
   output logic [IW-1:0]      rd_addr,
   input  wire slot_type      rd_data,
   output logic               wr_en,
   output logic [IW-1:0]      wr_addr,
   output slot_type           wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type        state_ff,      state_in;
   logic [CW-1:0]    cnt_ff,        cnt_in;
   req_type          req_ff,        req_in;
   logic             ok_ff,         ok_in;
   logic [SLOTS-1:0] active_ff,     active_in;
   logic             enable_ff,     enable_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff,       pend_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   rsp_type          rsp_ff,        rsp_in;

   logic          ev_on;
   logic [CW-1:0] ev_full;
   logic [IW-1:0] ev_idx;
   logic          ev_active;
   eval_type      ev;
   rsp_type       reading;

   // evaluation stage works on the entry addressed in the cycle before
   assign ev_on     = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign ev_full   = cnt_ff - CW'(1);
   assign ev_idx    = ev_full[IW-1:0];
   assign ev_active = ev_on && active_ff[ev_idx];
   assign rd_addr   = (cnt_ff < CW'(SLOTS)) ? cnt_ff[IW-1:0] : '0;

   adcsa_slot_unit u_unit (
      .req    (req_ff),
      .entry  (rd_data),
      .active (ev_active),
      .result (ev)
   );

   // reading built from the updated entry
   always_comb begin
      reading                 = '0;
      reading.result_kind     = RESULT_READING;
      reading.reading_handler = ev.wdata.handler;
      reading.reading_channel = ev.wdata.channel;
      reading.reading_value   = ev.wdata.value;
   end

   assign wr_addr = ev_idx;
   assign wr_data = ev.wdata;

   // next state
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      ok_in         = ok_ff;
      active_in     = active_ff;
      enable_in     = enable_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;

      // register write
      if (csr_valid) begin
         enable_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_data;
               ok_in         = 1'b0;
               pend_valid_in = 1'b0;
               cnt_in        = '0;
               case (req_data.kind)
                  KIND_SAMPLE: state_in = enable_ff ? ST_SCAN : ST_DONE;
                  KIND_CLEAR: begin
                     active_in = '0;
                     ok_in     = 1'b1;
                     state_in  = ST_DONE;
                  end
                  default: state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (ev_on) begin
               wr_en = ev.write;
               if (ev.set_active) begin
                  active_in[ev_idx] = 1'b1;
               end
               if (ev.clr_active) begin
                  active_in[ev_idx] = 1'b0;
               end
               if (ev.stop) begin
                  ok_in = 1'b1;
               end
               // flush the queued reading, queue the new one
               if (ev.emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_in       = reading;
                  pend_valid_in = 1'b1;
               end
            end
            if ((ev_on && ev.stop) || (cnt_ff == CW'(SLOTS))) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (req_ff.kind != KIND_SAMPLE) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.result_kind = RESULT_ACK;
               rsp_in.success = ok_ff;
               rsp_in.last    = 1'b1;
            end else if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               rsp_in.last  = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         ok_ff         <= 1'b0;
         active_ff     <= '0;
         enable_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ok_ff         <= ok_in;
         active_ff     <= active_in;
         enable_ff     <= enable_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // clear empties the table right after its transfer
   a_clear_frees_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_data.kind == KIND_CLEAR)
      |=> (active_ff == '0))
      else $error("clear left a slot active");

   // acknowledges always close their request
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_kind == RESULT_ACK) |-> rsp_ff.last)
      else $error("acknowledge without last");

   // a non-final reading only comes out of the table walk
   a_mid_from_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> ($past(state_ff) == ST_SCAN))
      else $error("non-final result outside the walk");

   // the walk never runs past the table
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CW'(SLOTS)))
      else $error("slot counter past the table");

   // the unit only writes while the walk evaluates a slot
   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (ev_on && $past(state_ff) != ST_DONE))
      else $error("table write outside the walk");

endmodule

`default_nettype wire

@@ src/adc_subscriber_sample_averager.sv @@
// ----------------------------------------------------------------------------
// adc_subscriber_sample_averager
// Table of subscriber slots that average ADC samples per channel and report
// a reading whenever a slot reaches its target sample count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (sample, add, cancel, clear) transfer on req_data when start is
//   high and busy is low. Results come on rsp_data, one per cycle, each marked
//   by a single-cycle rsp_valid strobe; the receiver cannot stall them, and
//   the final result of a request has last set.
//   Add, cancel and clear give one acknowledge; a sample gives one reading
//   per slot that reaches its target, possibly none.
//   A sample (enabled), add or cancel walks the slot table one entry
//   per cycle through the shared slot unit with a registered table read;
//   add and cancel stop at the first hit, and clear or a disabled sample
//   skips the walk. A new request is taken only once busy is low again.
//   The final result strobes in the first cycle with busy low again.
//   The enable register is written over csr_valid / csr_ready / csr_wdata,
//   always ready; the user must write it only while the block is idle,
//   as the block does not enforce this. Reset frees every slot and clears enable; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_subscriber_sample_averager
   import adcsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [IW-1:0] rd_addr;
   slot_type      rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   slot_type      wr_data;

   assign csr_ready = 1'b1;

   // sequencer with shared slot unit
   adcsa_ctrl #(
      .SLOTS (SLOTS),
      .IW    (IW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // slot table
   adcsa_slot_mem #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADC subscriber sample averager. A scoreboard
// keeps its own copy of the slot table and enable bit, works out the readings
// and acknowledges for every accepted request, and checks each result strobe
// field by field. Stimulus is a directed pass over the corner cases, then
// random subscribe/sample traffic.
// ----------------------------------------------------------------------------

module testbench;
   import adcsa_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int SETTLE      = SLOTS + 8;
   localparam int CYCLE_LIMIT = 200000;

   // slot table shadow and expected results
   class averager_scoreboard;
      bit          enabled;
      bit          slot_used [SLOTS];
      logic [7:0]  slot_id   [SLOTS];
      logic [4:0]  slot_chan [SLOTS];
      logic [7:0]  slot_goal [SLOTS];
      logic [7:0]  slot_tally[SLOTS];
      logic [11:0] slot_avg  [SLOTS];
      rsp_type     expected_results[$];
      int          failures;

      function new();
         enabled  = 1'b0;
         failures = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      function void set_enable(bit value);
         enabled = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function rsp_type ack(bit ok);
         rsp_type r;
         r                 = '0;
         r.result_kind     = RESULT_ACK;
         r.success         = ok;
         r.last            = 1'b1;
         return r;
      endfunction

      // work out the results of one accepted request
      function void note_request(req_type req);
         rsp_type     readings[$];
         rsp_type     r;
         logic [12:0] sum;
         bit          found;
         found = 1'b0;
         case (req.kind)
            KIND_SAMPLE: begin
               if (enabled) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (slot_used[i] && slot_chan[i] == req.channel) begin
                        slot_tally[i] = slot_tally[i] + 8'd1;
                        if (slot_tally[i] == 8'd1) begin
                           slot_avg[i] = req.sample_value;
                        end else begin
                           sum         = {1'b0, slot_avg[i]} + {1'b0, req.sample_value};
                           slot_avg[i] = sum[12:1];
                        end
                        if (slot_tally[i] == slot_goal[i]) begin
                           r                 = '0;
                           r.result_kind     = RESULT_READING;
                           r.reading_handler = slot_id[i];
                           r.reading_channel = slot_chan[i];
                           r.reading_value   = slot_avg[i];
                           readings.push_back(r);
                           slot_tally[i] = 8'd0;
                        end
                     end
                  end
                  if (readings.size() > 0) readings[readings.size() - 1].last = 1'b1;
                  foreach (readings[k]) expected_results.push_back(readings[k]);
               end
            end
            KIND_ADD: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && !slot_used[i]) begin
                     slot_used[i]  = 1'b1;
                     slot_id[i]    = req.handler_id;
                     slot_chan[i]  = req.channel;
                     slot_goal[i]  = req.average_count;
                     slot_tally[i] = 8'd0;
                     slot_avg[i]   = 12'd0;
                     found         = 1'b1;
                  end
               end
               expected_results.push_back(ack(found));
            end
            KIND_CANCEL: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found && slot_used[i] && slot_id[i] == req.handler_id &&
                      slot_chan[i] == req.channel) begin
                     slot_used[i] = 1'b0;
                     found        = 1'b1;
                  end
               end
               expected_results.push_back(ack(found));
            end
            default: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               expected_results.push_back(ack(1'b1));
            end
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      // compare one result strobe with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result %h with nothing pending", got);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("success", want.success, got.success);
         compare_field("reading_handler", want.reading_handler, got.reading_handler);
         compare_field("reading_channel", want.reading_channel, got.reading_channel);
         compare_field("reading_value", want.reading_value, got.reading_value);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    csr_valid = 1'b0;
   logic    csr_wdata = 1'b0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_ready;

   averager_scoreboard sb = new();
   logic [4:0]         hot_channels[4];
   int unsigned        cycle_count = 0;

   adc_subscriber_sample_averager #(
      .SLOTS(SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_type make_req(kind_type k, logic [4:0] c, logic [11:0] s,
                                        logic [7:0] h, logic [7:0] t);
      req_type r;
      r.kind          = k;
      r.channel       = c;
      r.sample_value  = s;
      r.handler_id    = h;
      r.average_count = t;
      return r;
   endfunction

   // mostly subscribe/sample traffic on a few busy channels, some noise
   function automatic req_type random_request();
      int unsigned p;
      int unsigned q;
      logic [4:0]  c;
      logic [7:0]  h;
      logic [7:0]  t;
      logic [11:0] s;
      p = $urandom_range(99);
      q = $urandom_range(9);
      c = hot_channels[$urandom_range(3)];
      h = 8'($urandom_range(1, 6));
      s = 12'($urandom_range(4095));
      t = (q == 0) ? 8'd0 : (q == 1) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
      if (p < 50) return make_req(KIND_SAMPLE, c, s, h, t);
      if (p < 70) return make_req(KIND_ADD, c, s, h, t);
      if (p < 85) return make_req(KIND_CANCEL, c, s, h, t);
      if (p < 88) return make_req(KIND_CLEAR, c, s, h, t);
      return make_req(kind_type'(2'($urandom_range(3))), 5'($urandom_range(31)), s,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
   endfunction

   // one request transfer; start stays high for the caller to decide
   task automatic send_request(req_type req);
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(req);
   endtask

   task automatic write_enable(bit value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_enable(value);
      csr_valid <= 1'b0;
   endtask

   // let every expected result arrive, then let the block settle
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int count, int idle_pct);
      foreach (hot_channels[i]) hot_channels[i] = 5'($urandom_range(31));
      for (int n = 0; n < count; n++) begin
         // sender idles at random before each request
         while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            req_data <= req_type'({$urandom, $urandom});
            @(posedge clock);
         end
         send_request(random_request());
      end
      drain();
   endtask

   // stimulus
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled: samples are ignored, table ops still acknowledge
      write_enable(1'b0);
      send_request(make_req(KIND_SAMPLE, 5'd0, 12'hFFF, 8'd0, 8'd0));
      send_request(make_req(KIND_ADD, 5'd0, 12'd0, 8'd0, 8'd1));
      send_request(make_req(KIND_SAMPLE, 5'd0, 12'h800, 8'd0, 8'd0));
      send_request(make_req(KIND_CLEAR, 5'd0, 12'd0, 8'd0, 8'd0));
      drain();

      // directed corner cases
      write_enable(1'b1);
      send_request(make_req(KIND_ADD, 5'd0, 12'd0, 8'd1, 8'd1));
      send_request(make_req(KIND_ADD, 5'd31, 12'd0, 8'd255, 8'd2));
      send_request(make_req(KIND_ADD, 5'd31, 12'd0, 8'd0, 8'd0));
      send_request(make_req(KIND_SAMPLE, 5'd31, 12'hFFF, 8'd0, 8'd0));
      send_request(make_req(KIND_SAMPLE, 5'd31, 12'h000, 8'd0, 8'd0));
      send_request(make_req(KIND_SAMPLE, 5'd0, 12'hFFF, 8'd0, 8'd0));
      send_request(make_req(KIND_SAMPLE, 5'd5, 12'hAAA, 8'd0, 8'd0));
      send_request(make_req(KIND_ADD, 5'd10, 12'd0, 8'h55, 8'd1));
      for (int i = 2; i < 6; i++) begin
         send_request(make_req(KIND_ADD, 5'd10, 12'd0, 8'(i), 8'd1));
      end
      // table full now
      send_request(make_req(KIND_ADD, 5'd1, 12'd0, 8'd9, 8'd1));
      send_request(make_req(KIND_SAMPLE, 5'd10, 12'h555, 8'd0, 8'd0));
      send_request(make_req(KIND_CANCEL, 5'd5, 12'd0, 8'd1, 8'd0));
      send_request(make_req(KIND_CANCEL, 5'd0, 12'd0, 8'd1, 8'd0));
      send_request(make_req(KIND_CANCEL, 5'd0, 12'd0, 8'd1, 8'd0));
      send_request(make_req(KIND_ADD, 5'd21, 12'd0, 8'hAA, 8'hFF));
      send_request(make_req(KIND_CANCEL, 5'd31, 12'd0, 8'd0, 8'd0));
      send_request(make_req(KIND_CLEAR, 5'd0, 12'd0, 8'd0, 8'd0));
      send_request(make_req(KIND_CANCEL, 5'd31, 12'd0, 8'd255, 8'd0));
      send_request(make_req(KIND_SAMPLE, 5'd10, 12'h123, 8'd0, 8'd0));
      drain();

      // random traffic, sender idling 21 %, then 54 %, then never
      random_phase(45, 21);
      write_enable(1'b0);
      random_phase(15, 54);
      write_enable(1'b1);
      random_phase(35, 54);
      random_phase(35, 0);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
